// File: rtl/core/hrvg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrvg_pkg
// Widths, constants and shared helpers of the hyperboloid ring vertex generator.
// ----------------------------------------------------------------------------
package hrvg_pkg;

    localparam int AXIS_W     = 16;
    localparam int C_W        = 10;
    localparam int H_W        = 11;
    localparam int SEG_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COORD_W    = 32;
    localparam int Z_W        = 11;

    localparam int DEF_MAX_SEGMENTS    = 64;
    localparam int DEF_COORD_FRAC_BITS = 8;

    // serial multiplier
    localparam int MUL_W     = 32;
    localparam int MUL_CNT_W = $clog2(MUL_W);
    // serial divider: long form for the radius and phase, short form for series terms
    localparam int DIV_W     = 54;
    localparam int DVSR_W    = 20;
    localparam int SHORT_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    // serial square root
    localparam int ROOT_W     = DIV_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);

    localparam logic [30:0]    Q30_ONE = 31'h4000_0000;
    localparam logic [29:0]    Q30_HALF = 30'h2000_0000;
    localparam logic [31:0]    PI_Q30  = 32'hC90F_DAA2;
    localparam logic [H_W-1:0] H_MAX   = 11'd2047;

    localparam logic [2:0] SIN_LAST_TERM = 3'd3;
    localparam logic [2:0] COS_LAST_TERM = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_A       = 3'd0,
        REG_AXIS_B       = 3'd1,
        REG_AXIS_C       = 3'd2,
        REG_HEIGHT_LIMIT = 3'd3,
        REG_SEGMENTS     = 3'd4
    } cfg_reg_t;

    // Horner divisors, highest order first
    function automatic logic [6:0] hrvg_horner_div(input logic is_cos, input logic [2:0] k);
        logic [6:0] d;
        d = 7'd2;
        if (is_cos) begin
            case (k)
                3'd0:    d = 7'd90;
                3'd1:    d = 7'd56;
                3'd2:    d = 7'd30;
                3'd3:    d = 7'd12;
                default: d = 7'd2;
            endcase
        end else begin
            case (k)
                3'd0:    d = 7'd72;
                3'd1:    d = 7'd42;
                3'd2:    d = 7'd20;
                default: d = 7'd6;
            endcase
        end
        return d;
    endfunction

endpackage

// File: rtl/core/hyperboloid_ring_vertex_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyperboloid_ring_vertex_generator
// Emits apex and ring vertices of a two-sheet hyperboloid, one item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, kind, lower_sheet): kind 0 starts a sheet
//   and gives one apex item; kind 1 gives the next ring of M vertex items, or a
//   single exhausted item once the height has passed height_limit.
//   Output channel (out_valid/out_ready): one result item per handshake, last set
//   on the final item of each input item.
//   Config port (cfg_we/cfg_index/cfg_data): write only, one cycle, while idle.
// Sequence:
//   Apex and exhausted items: result passes from the result to the output register.
//   Ring: first the radius (squaring, long divide, root; only the squaring when
//   the height is not above c), then for each vertex a long phase divide, 23
//   multiplies and short series divides, and a hand-over to the output register.
//   All of it runs through one bit-serial multiplier, one bit-serial divider and
//   a bit-serial square root; sine and cosine are Horner series built from the first two.
//   in_ready is high only between items.
// Reset: config returns to its defaults, ring height 0, step 1, upper sheet.
// Stall: a result waits in the output register; the sequencer carries on with
//   the next vertex and stops only when it has another result to hand over.
// ----------------------------------------------------------------------------
module hyperboloid_ring_vertex_generator
    import hrvg_pkg::*;
#(
    parameter int MAX_SEGMENTS    = DEF_MAX_SEGMENTS,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    // input items
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      kind,
    input  logic                      lower_sheet,
    // result items
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] vertex_x,
    output logic signed [COORD_W-1:0] vertex_y,
    output logic signed [Z_W-1:0]     vertex_z,
    output logic                      is_apex,
    output logic                      exhausted,
    output logic                      last
);

    localparam int JW    = $clog2(MAX_SEGMENTS);
    localparam int SHIFT = 24 - COORD_FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_RDIV, S_RSQ, S_PDIV, S_THM, S_X2M, S_HDIV, S_HMUL,
        S_SINF, S_XM1, S_XM2, S_YM1, S_YM2, S_EMIT
    } state_t;

    // ---------------- configuration registers ----------------
    logic [AXIS_W-1:0] axis_a_reg, axis_b_reg;
    logic [C_W-1:0]    axis_c_reg, height_limit_reg;
    logic [SEG_W-1:0]  segments_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            axis_a_reg       <= 16'd256;
            axis_b_reg       <= 16'd256;
            axis_c_reg       <= 10'd1;
            height_limit_reg <= 10'd250;
            segments_reg     <= 7'd20;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_AXIS_A:       axis_a_reg       <= cfg_data[AXIS_W-1:0];
                REG_AXIS_B:       axis_b_reg       <= cfg_data[AXIS_W-1:0];
                REG_AXIS_C:       axis_c_reg       <= cfg_data[C_W-1:0];
                REG_HEIGHT_LIMIT: height_limit_reg <= cfg_data[C_W-1:0];
                REG_SEGMENTS:     segments_reg     <= cfg_data[SEG_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- sequencer state ----------------
    state_t              state_reg;
    logic                launched_reg;
    logic [H_W-1:0]      ring_height_reg, height_step_reg;
    logic                sheet_sign_reg;
    logic [SEG_W-1:0]    m_reg;
    logic [JW-1:0]       j_reg;
    logic [2*H_W-1:0]    hh_reg;
    logic [2*C_W-1:0]    cc_reg;
    logic [ROOT_W-1:0]   r_reg;
    logic [1:0]          quad_reg;
    logic                swap_reg;
    logic [29:0]         qa_reg;
    logic [29:0]         th_reg, x2_reg, u_reg;
    logic [30:0]         t_reg, sin0_reg, cos0_reg;
    logic [2:0]          k_reg;
    logic                is_cos_reg;
    logic [27:0]         rc_reg;
    logic                emit_vertex_reg;
    logic [COORD_W-1:0]  res_x_reg, res_y_reg;
    logic [Z_W-1:0]      res_z_reg;
    logic                res_apex_reg, res_exh_reg, res_last_reg;
    logic                out_valid_reg;
    logic [COORD_W-1:0]  out_x_reg, out_y_reg;
    logic [Z_W-1:0]      out_z_reg;
    logic                out_apex_reg, out_exh_reg, out_last_reg;

    // ---------------- arithmetic units ----------------
    logic                 use_mul, use_div, use_sqrt, div_short;
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   mul_prod;
    logic                 mul_done, div_done, sqrt_done, op_done;
    logic [DIV_W-1:0]     div_dividend, div_quot;
    logic [DVSR_W-1:0]    div_divisor;
    logic [ROOT_W-1:0]    sqrt_root;

    hrvg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (use_mul && !launched_reg),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    hrvg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (use_div && !launched_reg),
        .is_short (div_short),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    hrvg_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (use_sqrt && !launched_reg),
        .radicand (div_quot),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign op_done = (use_mul && mul_done) || (use_div && div_done) || (use_sqrt && sqrt_done);

    // quadrant mapping of the first-quadrant sine and cosine
    logic [30:0] c0, s0, cm, sm;
    logic        cn, sn;

    always_comb begin
        c0 = swap_reg ? sin0_reg : cos0_reg;
        s0 = swap_reg ? cos0_reg : sin0_reg;
        case (quad_reg)
            2'd0:    begin cm = c0; cn = 1'b0; sm = s0; sn = 1'b0; end
            2'd1:    begin cm = s0; cn = 1'b1; sm = c0; sn = 1'b0; end
            2'd2:    begin cm = c0; cn = 1'b1; sm = s0; sn = 1'b1; end
            default: begin cm = s0; cn = 1'b0; sm = c0; sn = 1'b1; end
        endcase
    end

    // operand selection
    always_comb begin
        use_mul      = 1'b0;
        use_div      = 1'b0;
        use_sqrt     = 1'b0;
        div_short    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_dividend = '0;
        div_divisor  = '0;
        case (state_reg)
            S_RDIV: begin
                use_div      = 1'b1;
                div_dividend = {22'(hh_reg - {2'b00, cc_reg}), 32'd0};
                div_divisor  = cc_reg;
            end
            S_RSQ: use_sqrt = 1'b1;
            S_PDIV: begin
                use_div      = 1'b1;
                div_dividend = DIV_W'({j_reg, 32'd0});
                div_divisor  = DVSR_W'(m_reg);
            end
            S_THM: begin
                use_mul = 1'b1;
                mul_a   = {2'b00, qa_reg};
                mul_b   = PI_Q30;
            end
            S_X2M: begin
                use_mul = 1'b1;
                mul_a   = {2'b00, th_reg};
                mul_b   = {2'b00, th_reg};
            end
            S_HDIV: begin
                use_div      = 1'b1;
                div_short    = 1'b1;
                div_dividend = DIV_W'(u_reg);
                div_divisor  = DVSR_W'(hrvg_horner_div(is_cos_reg, k_reg));
            end
            S_HMUL: begin
                use_mul = 1'b1;
                mul_a   = {2'b00, x2_reg};
                mul_b   = {1'b0, t_reg};
            end
            S_SINF: begin
                use_mul = 1'b1;
                mul_a   = {2'b00, th_reg};
                mul_b   = {1'b0, t_reg};
            end
            S_XM1: begin
                use_mul = 1'b1;
                mul_a   = MUL_W'(r_reg);
                mul_b   = {1'b0, cm};
            end
            S_YM1: begin
                use_mul = 1'b1;
                mul_a   = MUL_W'(r_reg);
                mul_b   = {1'b0, sm};
            end
            S_XM2: begin
                use_mul = 1'b1;
                mul_a   = MUL_W'(axis_a_reg);
                mul_b   = MUL_W'(rc_reg);
            end
            S_YM2: begin
                use_mul = 1'b1;
                mul_a   = MUL_W'(axis_b_reg);
                mul_b   = MUL_W'(rc_reg);
            end
            default: ;
        endcase
    end

    // coordinate scaling and saturation
    logic [2*MUL_W-1:0] mag;
    logic [2*MUL_W-1:0] mag_neg;
    logic               coord_neg;
    logic [COORD_W-1:0] coord_val;

    always_comb begin
        mag       = mul_prod >> SHIFT;
        coord_neg = (state_reg == S_XM2) ? cn : sn;
        mag_neg   = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
        if (coord_neg) begin
            coord_val = 32'd0 - mag_neg[COORD_W-1:0];
        end else if (mag > 64'h7FFF_FFFF) begin
            coord_val = 32'h7FFF_FFFF;
        end else begin
            coord_val = mag[COORD_W-1:0];
        end
    end

    // misc derived values
    logic [C_W-1:0]   c_eff;
    logic [SEG_W-1:0] m_clamp;
    logic [H_W:0]     step_sum, height_sum;
    logic [30:0]      t_new;
    logic [29:0]      ph_q;
    logic             out_free;
    logic             load_out;

    assign c_eff      = (axis_c_reg == '0) ? C_W'(1) : axis_c_reg;
    assign m_clamp    = (segments_reg < SEG_W'(3)) ? SEG_W'(3) :
                        (segments_reg > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) :
                        segments_reg;
    assign step_sum   = {1'b0, height_step_reg} + (H_W+1)'(3);
    assign height_sum = {1'b0, ring_height_reg} + {1'b0, height_step_reg};
    assign t_new      = Q30_ONE - {1'b0, div_quot[29:0]};
    assign ph_q       = div_quot[29:0];
    assign out_free   = !out_valid_reg || out_ready;
    assign load_out   = (state_reg == S_EMIT) && out_free;

    function automatic logic [Z_W-1:0] enc_z(input logic [H_W-1:0] m, input logic neg);
        return neg ? Z_W'(11'd0 - m) : Z_W'(m);
    endfunction

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg       <= S_IDLE;
            launched_reg    <= 1'b0;
            ring_height_reg <= '0;
            height_step_reg <= H_W'(1);
            sheet_sign_reg  <= 1'b0;
            m_reg           <= '0;
            j_reg           <= '0;
            k_reg           <= '0;
            is_cos_reg      <= 1'b0;
            emit_vertex_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            hh_reg          <= '0;
            cc_reg          <= '0;
            r_reg           <= '0;
            quad_reg        <= '0;
            swap_reg        <= 1'b0;
            qa_reg          <= '0;
            th_reg          <= '0;
            x2_reg          <= '0;
            u_reg           <= '0;
            t_reg           <= '0;
            sin0_reg        <= '0;
            cos0_reg        <= '0;
            rc_reg          <= '0;
            res_x_reg       <= '0;
            res_y_reg       <= '0;
            res_z_reg       <= '0;
            res_apex_reg    <= 1'b0;
            res_exh_reg     <= 1'b0;
            res_last_reg    <= 1'b0;
            out_x_reg       <= '0;
            out_y_reg       <= '0;
            out_z_reg       <= '0;
            out_apex_reg    <= 1'b0;
            out_exh_reg     <= 1'b0;
            out_last_reg    <= 1'b0;
        end else begin
            // output register: a new item replaces a taken one in the same cycle
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (use_mul || use_div || use_sqrt) begin
                launched_reg <= !op_done;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        if (!kind) begin
                            sheet_sign_reg  <= lower_sheet;
                            ring_height_reg <= H_W'(axis_c_reg) + H_W'(1);
                            height_step_reg <= H_W'(1);
                            res_x_reg       <= '0;
                            res_y_reg       <= '0;
                            res_z_reg       <= enc_z(H_W'(axis_c_reg), lower_sheet);
                            res_apex_reg    <= 1'b1;
                            res_exh_reg     <= 1'b0;
                            res_last_reg    <= 1'b1;
                            emit_vertex_reg <= 1'b0;
                            state_reg       <= S_EMIT;
                        end else if (ring_height_reg > H_W'(height_limit_reg)) begin
                            res_x_reg       <= '0;
                            res_y_reg       <= '0;
                            res_z_reg       <= '0;
                            res_apex_reg    <= 1'b0;
                            res_exh_reg     <= 1'b1;
                            res_last_reg    <= 1'b1;
                            emit_vertex_reg <= 1'b0;
                            state_reg       <= S_EMIT;
                        end else begin
                            height_step_reg <= step_sum[H_W] ? H_MAX : step_sum[H_W-1:0];
                            m_reg           <= m_clamp;
                            j_reg           <= '0;
                            state_reg       <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    hh_reg <= (2*H_W)'(ring_height_reg) * (2*H_W)'(ring_height_reg);
                    cc_reg <= (2*C_W)'(c_eff) * (2*C_W)'(c_eff);
                    if (ring_height_reg > H_W'(c_eff)) begin
                        state_reg <= S_RDIV;
                    end else begin
                        r_reg     <= '0;
                        state_reg <= S_PDIV;
                    end
                end
                S_RDIV: begin
                    if (op_done) begin
                        state_reg <= S_RSQ;
                    end
                end
                S_RSQ: begin
                    if (op_done) begin
                        r_reg     <= sqrt_root;
                        state_reg <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    if (op_done) begin
                        quad_reg  <= div_quot[31:30];
                        swap_reg  <= ph_q > Q30_HALF;
                        qa_reg    <= (ph_q > Q30_HALF) ? 30'(Q30_ONE - {1'b0, ph_q}) : ph_q;
                        state_reg <= S_THM;
                    end
                end
                S_THM: begin
                    if (op_done) begin
                        th_reg    <= mul_prod[60:31];
                        state_reg <= S_X2M;
                    end
                end
                S_X2M: begin
                    if (op_done) begin
                        x2_reg     <= mul_prod[59:30];
                        u_reg      <= mul_prod[59:30];
                        k_reg      <= '0;
                        is_cos_reg <= 1'b0;
                        state_reg  <= S_HDIV;
                    end
                end
                S_HDIV: begin
                    if (op_done) begin
                        t_reg <= t_new;
                        k_reg <= k_reg + 1'b1;
                        if (is_cos_reg && k_reg == COS_LAST_TERM) begin
                            cos0_reg  <= t_new;
                            state_reg <= S_XM1;
                        end else if (!is_cos_reg && k_reg == SIN_LAST_TERM) begin
                            state_reg <= S_SINF;
                        end else begin
                            state_reg <= S_HMUL;
                        end
                    end
                end
                S_HMUL: begin
                    if (op_done) begin
                        u_reg     <= mul_prod[59:30];
                        state_reg <= S_HDIV;
                    end
                end
                S_SINF: begin
                    if (op_done) begin
                        sin0_reg   <= mul_prod[60:30];
                        is_cos_reg <= 1'b1;
                        k_reg      <= '0;
                        u_reg      <= x2_reg;
                        state_reg  <= S_HDIV;
                    end
                end
                S_XM1: begin
                    if (op_done) begin
                        rc_reg    <= mul_prod[57:30];
                        state_reg <= S_XM2;
                    end
                end
                S_XM2: begin
                    if (op_done) begin
                        res_x_reg <= coord_val;
                        state_reg <= S_YM1;
                    end
                end
                S_YM1: begin
                    if (op_done) begin
                        rc_reg    <= mul_prod[57:30];
                        state_reg <= S_YM2;
                    end
                end
                S_YM2: begin
                    if (op_done) begin
                        res_y_reg       <= coord_val;
                        res_z_reg       <= enc_z(ring_height_reg, sheet_sign_reg);
                        res_apex_reg    <= 1'b0;
                        res_exh_reg     <= 1'b0;
                        res_last_reg    <= SEG_W'(j_reg) == (m_reg - SEG_W'(1));
                        emit_vertex_reg <= 1'b1;
                        state_reg       <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        out_x_reg     <= res_x_reg;
                        out_y_reg     <= res_y_reg;
                        out_z_reg     <= res_z_reg;
                        out_apex_reg  <= res_apex_reg;
                        out_exh_reg   <= res_exh_reg;
                        out_last_reg  <= res_last_reg;
                        if (emit_vertex_reg && !res_last_reg) begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_PDIV;
                        end else begin
                            if (emit_vertex_reg) begin
                                ring_height_reg <= height_sum[H_W] ? H_MAX
                                                                   : height_sum[H_W-1:0];
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign vertex_x  = out_x_reg;
    assign vertex_y  = out_y_reg;
    assign vertex_z  = out_z_reg;
    assign is_apex   = out_apex_reg;
    assign exhausted = out_exh_reg;
    assign last      = out_last_reg;

endmodule

// File: rtl/core/hrvg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrvg_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module hrvg_mul
    import hrvg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic                 done,
    output logic [2*MUL_W-1:0]   prod
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_W-1:0]     a_reg;
    logic [2*MUL_W-1:0]   prod_reg;
    logic [MUL_W:0]       add_next;

    // partial sum on the upper half, product shifts right
    assign add_next = {1'b0, prod_reg[2*MUL_W-1:MUL_W]}
                    + (prod_reg[0] ? {1'b0, a_reg} : {(MUL_W+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            a_reg    <= a;
            prod_reg <= {{MUL_W{1'b0}}, b};
        end else if (busy_reg) begin
            prod_reg <= {add_next, prod_reg[MUL_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// File: rtl/core/hrvg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrvg_div
// Restoring divider, one quotient bit per cycle; short form for 32-bit dividends.
// ----------------------------------------------------------------------------
module hrvg_div
    import hrvg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              is_short,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] last_reg;
    logic [DVSR_W-1:0]    dvsr_reg;
    logic [DVSR_W-1:0]    rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DVSR_W+1:0]    diff;

    assign diff = {1'b0, rem_reg, quo_reg[DIV_W-1]} - {2'b00, dvsr_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            last_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                last_reg <= is_short ? DIV_CNT_W'(SHORT_W - 1) : DIV_CNT_W'(DIV_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == last_reg) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            dvsr_reg <= divisor;
            rem_reg  <= '0;
            if (is_short) begin
                quo_reg <= {dividend[SHORT_W-1:0], {(DIV_W-SHORT_W){1'b0}}};
            end else begin
                quo_reg <= dividend;
            end
        end else if (busy_reg) begin
            if (!diff[DVSR_W+1]) begin
                rem_reg <= diff[DVSR_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[DVSR_W-2:0], quo_reg[DIV_W-1]};
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/hrvg_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrvg_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module hrvg_isqrt
    import hrvg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]      rad_reg;
    logic [ROOT_W+1:0]     rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_W+3:0]     rem_sh;
    logic [ROOT_W+3:0]     trial;

    assign rem_sh = {rem_reg, rad_reg[DIV_W-1:DIV_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ROOT_CNT_W'(ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[DIV_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= (ROOT_W+2)'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: rtl/core/hrvg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrvg_checker
// Port-level checks on the vertex generator, bound to the top level.
// ----------------------------------------------------------------------------
module hrvg_checker
    import hrvg_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [COORD_W-1:0] vertex_x,
    input logic signed [COORD_W-1:0] vertex_y,
    input logic signed [Z_W-1:0]     vertex_z,
    input logic                      is_apex,
    input logic                      exhausted,
    input logic                      last
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vertex_x) && $stable(vertex_y)
            && $stable(vertex_z) && $stable(last))
        else $error("result item changed while stalled");

    // one item at a time: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    // apex and exhausted markers are single, closing items
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (is_apex || exhausted) |-> last && !(is_apex && exhausted))
        else $error("marker item without last");

    a_apex_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_apex |-> vertex_x == 0 && vertex_y == 0)
        else $error("apex off axis");

    a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |-> vertex_x == 0 && vertex_y == 0 && vertex_z == 0)
        else $error("exhausted marker carries coordinates");

endmodule

bind hyperboloid_ring_vertex_generator hrvg_checker u_hrvg_checker (.*);

// File: bench/hyperboloid_ring_vertex_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hyperboloid_ring_vertex_generator_tb
// Self-checking bench for the hyperboloid ring vertex generator.
// A directed table (register writes and items, some with typed-in results)
// runs first, then randomised phases with fresh register settings. Every
// accepted item is run through a local fixed-point model of the block; each
// result item is checked field by field against the oldest expected vertex.
// ----------------------------------------------------------------------------
module hyperboloid_ring_vertex_generator_tb;
    import hrvg_pkg::*;

    localparam int          FRAC_BITS    = DEF_COORD_FRAC_BITS;
    localparam int          SEG_MAX      = DEF_MAX_SEGMENTS;
    localparam int          HEIGHT_SAT   = 2047;
    localparam int          LIMIT_CYCLES = 20_000_000;
    localparam int          SETTLE       = 10;
    localparam logic        KIND_START   = 1'b0;
    localparam logic        KIND_RING    = 1'b1;
    // register index past the end of the map, must be ignored
    localparam logic [2:0]  REG_SPARE    = 3'd5;
    localparam logic [63:0] ONE_Q30      = 64'h4000_0000;
    localparam logic [63:0] PI_TURN_Q30  = 64'hC90F_DAA2;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [10:0] z;
        logic        apex;
        logic        exh;
        logic        last;
    } vertex_t;

    typedef struct {
        logic [63:0] cm;
        logic [63:0] sm;
        bit          cn;
        bit          sn;
    } trig_t;

    // one row of the directed table: either a register write or an item
    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [15:0] data;
        logic        kind;
        logic        lower;
        bit          typed;
        vertex_t     exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic        lower_sheet;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [10:0] vertex_z;
    logic        is_apex;
    logic        exhausted;
    logic        last;

    hyperboloid_ring_vertex_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .lower_sheet(lower_sheet),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .vertex_x   (vertex_x),
        .vertex_y   (vertex_y),
        .vertex_z   (vertex_z),
        .is_apex    (is_apex),
        .exhausted  (exhausted),
        .last       (last)
    );

    // mirror of the register file and of the sheet state
    int unsigned reg_a, reg_b, reg_c, reg_limit, reg_seg;
    int unsigned ring_h, ring_step;
    logic        on_lower;

    vertex_t     expected_vertices[$];
    row_t        directed_rows[$];
    bit          quiet;          // no idling on either side
    int          errors;
    int          items_sent;
    int          vertices_seen;
    int          apex_seen;
    int          exhausted_seen;
    longint      cycles;

    // ------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d vertices outstanding",
                     cycles, expected_vertices.size());
            $display("[hyperboloid_ring_vertex_generator] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // fixed-point model of the vertex maths
    // ------------------------------------------------------------------
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] sine_series(input logic [63:0] a);
        logic [63:0] a2, t;
        a2 = (a * a) >> 30;
        t  = ONE_Q30 - a2 / 72;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 6;
        return (a * t) >> 30;
    endfunction

    function automatic logic [63:0] cosine_series(input logic [63:0] a);
        logic [63:0] a2, t;
        a2 = (a * a) >> 30;
        t  = ONE_Q30 - a2 / 90;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 56;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 30;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 12;
        t  = ONE_Q30 - ((a2 * t) >> 30) / 2;
        return t;
    endfunction

    // cos/sin magnitude and sign for a phase in turns (32-bit fraction)
    function automatic trig_t phase_trig(input logic [63:0] p);
        logic [1:0]  quad;
        logic [63:0] q, c0, s0, th;
        trig_t       t;
        quad = p[31:30];
        q    = p & (ONE_Q30 - 1);
        if (q <= (ONE_Q30 >> 1))
        begin
            th = (q * PI_TURN_Q30) >> 31;
            c0 = cosine_series(th);
            s0 = sine_series(th);
        end
        else
        begin
            // past the octant: use the complement, sin and cos swap
            th = ((ONE_Q30 - q) * PI_TURN_Q30) >> 31;
            c0 = sine_series(th);
            s0 = cosine_series(th);
        end
        case (quad)
            2'd0:    begin t.cm = c0; t.cn = 0; t.sm = s0; t.sn = 0; end
            2'd1:    begin t.cm = s0; t.cn = 1; t.sm = c0; t.sn = 0; end
            2'd2:    begin t.cm = c0; t.cn = 1; t.sm = s0; t.sn = 1; end
            default: begin t.cm = s0; t.cn = 0; t.sm = c0; t.sn = 1; end
        endcase
        return t;
    endfunction

    function automatic logic [31:0] coord_val(input int unsigned axis, input logic [63:0] r,
                                              input logic [63:0] tm, input bit neg);
        logic [63:0] rc, mag;
        rc  = (r * tm) >> 30;
        mag = (64'(axis) * rc) >> (24 - FRAC_BITS);
        if (neg)
        begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return 32'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic logic [10:0] encode_z(input int unsigned mag, input logic neg);
        logic [10:0] m;
        m = mag[10:0];
        return neg ? 11'(-m) : m;
    endfunction

    // append one vertex to the expected queue
    function automatic void expect_vertex(input vertex_t v);
        expected_vertices = {expected_vertices, v};
    endfunction

    // advance the sheet state for one item; queue its vertices when asked
    task automatic predict_item(input logic k, input logic low, input bit push);
        int unsigned m;
        logic [63:0] h, c, r, p;
        trig_t       t;
        vertex_t     v;
        v = '0;
        if (k == KIND_START)
        begin
            on_lower  = low;
            ring_h    = reg_c + 1;
            ring_step = 1;
            v.z       = encode_z(reg_c, low);
            v.apex    = 1'b1;
            v.last    = 1'b1;
            if (push)
                expect_vertex(v);
            return;
        end
        if (ring_h > reg_limit)
        begin
            // past the limit: one marker, state untouched
            v.exh  = 1'b1;
            v.last = 1'b1;
            if (push)
                expect_vertex(v);
            return;
        end
        m = reg_seg;
        if (m < 3)
            m = 3;
        if (m > SEG_MAX)
            m = SEG_MAX;
        ring_step = ring_step + 3;
        if (ring_step > HEIGHT_SAT)
            ring_step = HEIGHT_SAT;
        c = (reg_c != 0) ? reg_c : 1;
        h = ring_h;
        r = 0;
        if (h > c)
            r = int_sqrt(((h * h - c * c) << 32) / (c * c));
        for (int j = 0; j < m; j++)
        begin
            p      = (64'(j) << 32) / m;
            t      = phase_trig(p);
            v.x    = coord_val(reg_a, r, t.cm, t.cn);
            v.y    = coord_val(reg_b, r, t.sm, t.sn);
            v.z    = encode_z(ring_h, on_lower);
            v.last = (j == m - 1);
            if (push)
                expect_vertex(v);
        end
        ring_h = ring_h + ring_step;
        if (ring_h > HEIGHT_SAT)
            ring_h = HEIGHT_SAT;
    endtask

    // ------------------------------------------------------------------
    // result side: random back-pressure and the checker
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= quiet || ($urandom_range(0, 99) >= 24);
    end

    task automatic check_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_vertices.size() == 0)
            begin
                $display("%0t: unexpected result item x=%h y=%h z=%h", $time,
                         vertex_x, vertex_y, vertex_z);
                errors++;
            end
            else
            begin
                e = expected_vertices.pop_front();
                check_field("vertex_x", e.x, vertex_x);
                check_field("vertex_y", e.y, vertex_y);
                check_field("vertex_z", 32'(e.z), 32'($unsigned(vertex_z)));
                check_field("is_apex", 32'(e.apex), 32'(is_apex));
                check_field("exhausted", 32'(e.exh), 32'(exhausted));
                check_field("last", 32'(e.last), 32'(last));
                vertices_seen++;
                apex_seen      += is_apex;
                exhausted_seen += exhausted;
            end
        end
    end

    // ------------------------------------------------------------------
    // item side
    // ------------------------------------------------------------------
    // offers one item from a falling edge after random idle gaps, returns at the accepting edge
    task automatic send_item(input logic k, input logic low, input bit typed,
                             input vertex_t exp);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        lower_sheet <= low;
        do
            @(posedge clk);
        while (!in_ready);
        predict_item(k, low, !typed);
        if (typed)
            expect_vertex(exp);
        items_sent++;
    endtask

    // let the block run dry, then idle for the SETTLE margin
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // register write: the block must be idle
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_AXIS_A:       reg_a     = val;
            REG_AXIS_B:       reg_b     = val;
            REG_AXIS_C:       reg_c     = val[9:0];
            REG_HEIGHT_LIMIT: reg_limit = val[9:0];
            REG_SEGMENTS:     reg_seg   = val[6:0];
            default:          ;
        endcase
    endtask

    function automatic void add_cfg(input logic [2:0] idx, input logic [15:0] val);
        row_t r;
        r        = '{default: '0};
        r.is_cfg = 1;
        r.idx    = idx;
        r.data   = val;
        directed_rows = {directed_rows, r};
    endfunction

    function automatic void add_item(input logic k, input logic low, input bit typed,
                                     input vertex_t exp);
        row_t r;
        r       = '{default: '0};
        r.kind  = k;
        r.lower = low;
        r.typed = typed;
        r.exp   = exp;
        directed_rows = {directed_rows, r};
    endfunction

    function automatic vertex_t apex_at(input logic [10:0] z);
        vertex_t v;
        v      = '0;
        v.z    = z;
        v.apex = 1'b1;
        v.last = 1'b1;
        return v;
    endfunction

    function automatic logic [15:0] pick_axis;
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'd1;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        vertex_t none;
        vertex_t marker;
        row_t    row;
        bit      in_stream;
        int      phase_items;

        none           = '0;
        marker         = '0;
        marker.exh     = 1'b1;
        marker.last    = 1'b1;
        errors         = 0;
        items_sent     = 0;
        vertices_seen  = 0;
        apex_seen      = 0;
        exhausted_seen = 0;
        cycles         = 0;
        quiet          = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        kind           = KIND_START;
        lower_sheet    = 1'b0;
        out_ready      = 1'b0;
        reg_a          = 256;
        reg_b          = 256;
        reg_c          = 1;
        reg_limit      = 250;
        reg_seg        = 20;
        ring_h         = 0;
        ring_step      = 1;
        on_lower       = 1'b0;

        // reset defaults first: a ring before any start sits at height 0
        add_item(KIND_RING, 1'b0, 0, none);
        add_item(KIND_START, 1'b0, 1, apex_at(11'd1));
        add_item(KIND_START, 1'b1, 1, apex_at(11'h7FF));
        add_item(KIND_RING, 1'b0, 0, none);
        // extremes; segments below range clamps up, spare index ignored
        add_cfg(REG_SEGMENTS, 16'd2);
        add_cfg(REG_AXIS_A, 16'hFFFF);
        add_cfg(REG_AXIS_B, 16'd1);
        add_cfg(REG_AXIS_C, 16'd1023);
        add_cfg(REG_HEIGHT_LIMIT, 16'd1023);
        add_cfg(REG_SPARE, 16'hFFFF);
        add_item(KIND_START, 1'b0, 1, apex_at(11'd1023));
        add_item(KIND_RING, 1'b1, 1, marker);
        // zero apex height: the radius divides by one
        add_cfg(REG_AXIS_C, 16'd0);
        add_item(KIND_START, 1'b1, 1, apex_at(11'd0));
        add_item(KIND_RING, 1'b0, 0, none);
        add_item(KIND_RING, 1'b1, 0, none);
        // c raised after the start: height not above c gives r = 0
        add_cfg(REG_AXIS_C, 16'd5);
        add_item(KIND_START, 1'b0, 1, apex_at(11'd5));
        add_cfg(REG_AXIS_C, 16'd100);
        add_item(KIND_RING, 1'b0, 0, none);
        // segments above range clamps to the maximum ring
        add_cfg(REG_SEGMENTS, 16'd127);
        add_cfg(REG_AXIS_A, 16'd1);
        add_cfg(REG_AXIS_B, 16'hFFFF);
        add_cfg(REG_AXIS_C, 16'd3);
        add_item(KIND_START, 1'b0, 1, apex_at(11'd3));
        add_item(KIND_RING, 1'b0, 0, none);
        // limit of zero: exhausted straight after the start
        add_cfg(REG_SEGMENTS, 16'd0);
        add_cfg(REG_HEIGHT_LIMIT, 16'd0);
        add_cfg(REG_AXIS_C, 16'd2);
        add_item(KIND_START, 1'b1, 1, apex_at(11'h7FE));
        add_item(KIND_RING, 1'b0, 1, marker);
        add_item(KIND_RING, 1'b1, 1, marker);
        // a short climb up to the limit
        add_cfg(REG_SEGMENTS, 16'd3);
        add_cfg(REG_HEIGHT_LIMIT, 16'd10);
        add_cfg(REG_AXIS_C, 16'd1);
        add_cfg(REG_AXIS_A, 16'd256);
        add_cfg(REG_AXIS_B, 16'd256);
        add_item(KIND_START, 1'b0, 1, apex_at(11'd1));
        add_item(KIND_RING, 1'b0, 0, none);
        add_item(KIND_RING, 1'b0, 0, none);
        add_item(KIND_RING, 1'b0, 1, marker);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table; register rows wait for the block to go idle
        in_stream = 0;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                if (in_stream)
                    drain();
                in_stream = 0;
                write_reg(row.idx, row.data);
            end
            else
            begin
                send_item(row.kind, row.lower, row.typed, row.exp);
                in_stream = 1;
            end
        end
        drain();

        // random phases, each with its own register setting
        for (int ph = 0; ph < 9; ph++)
        begin
            quiet = (ph == 1);
            write_reg(REG_AXIS_A, pick_axis());
            write_reg(REG_AXIS_B, pick_axis());
            case ($urandom_range(0, 9))
                0:       write_reg(REG_AXIS_C, 16'd0);
                1:       write_reg(REG_AXIS_C, 16'd1023);
                default: write_reg(REG_AXIS_C, 16'($urandom_range(1, 20)));
            endcase
            write_reg(REG_HEIGHT_LIMIT, ($urandom_range(0, 9) == 0)
                      ? 16'd1023 : 16'($urandom_range(1, 300)));
            // mostly short rings to keep the run length sane
            write_reg(REG_SEGMENTS, ($urandom_range(0, 19) == 0)
                      ? 16'($urandom_range(0, 10)) : 16'($urandom_range(3, 6)));
            // every phase opens a sheet, then mostly rings with the odd restart
            send_item(KIND_START, 1'($urandom_range(0, 1)), 0, none);
            phase_items = 39;
            for (int n = 0; n < phase_items; n++)
            begin
                if (ph == 4 && n == 20)
                    drain();
                if ($urandom_range(0, 99) < 18)
                    send_item(KIND_START, 1'($urandom_range(0, 1)), 0, none);
                else
                    send_item(KIND_RING, 1'($urandom_range(0, 1)), 0, none);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("%0d items sent, %0d results checked (%0d apex, %0d exhausted)",
                 items_sent, vertices_seen, apex_seen, exhausted_seen);
        $display("covered reset defaults, axis and segment extremes, zero c and limit");
        if (errors == 0)
            $display("[hyperboloid_ring_vertex_generator] OK");
        else
            $display("[hyperboloid_ring_vertex_generator] ERROR");
        $finish;
    end

endmodule
